FILE: hw/rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque: sizes, operation
// and status codes, and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // store geometry; DEPTH must be a power of two so pointers wrap by masking
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);

  // port widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 4;

  // pointer reset values
  localparam logic [PTR_W-1:0] FRONT_RESET = PTR_W'(DEPTH / 2);
  localparam logic [PTR_W-1:0] BACK_RESET  = PTR_W'(DEPTH / 2 - 1);
  localparam logic [PTR_W-1:0] LEN_FULL    = PTR_W'(DEPTH - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // capture the accepted beat
    logic exec;      // run the operation and access the store
    logic load_out;  // move the result into the output registers
  } rbd_cmd_t;

endpackage

FILE: hw/rtl/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer for the deque: accepts one beat, steps it through execute and
// result load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rbd_pkg::rbd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;

  // take a beat only when idle and the output slot is free by the next edge
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // command decode
  assign cmd.load_in  = in_valid && in_ready;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.load_out = (state == S_LOAD);

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/rbd_datapath.sv
// ----------------------------------------------------------------------------
// rbd_datapath
// Slot store, front and back pointers, length and status logic, and the
// output registers of the deque.
// ----------------------------------------------------------------------------
module rbd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rbd_pkg::rbd_cmd_t                 cmd,
  input  logic [rbd_pkg::OP_W-1:0]          op,
  input  logic [rbd_pkg::VALUE_W-1:0]       value,
  output logic [rbd_pkg::VALUE_W-1:0]       data,
  output logic [rbd_pkg::STATUS_W-1:0]      status,
  output logic [rbd_pkg::LENGTH_W-1:0]      length
);

  logic [rbd_pkg::DATA_WIDTH-1:0] slots [rbd_pkg::DEPTH];

  logic [rbd_pkg::OP_W-1:0]       op_q;
  logic [rbd_pkg::DATA_WIDTH-1:0] value_q;
  logic [rbd_pkg::PTR_W-1:0]      front_ptr;
  logic [rbd_pkg::PTR_W-1:0]      back_ptr;
  logic [rbd_pkg::PTR_W-1:0]      front_ptr_next;
  logic [rbd_pkg::PTR_W-1:0]      back_ptr_next;
  logic [rbd_pkg::DATA_WIDTH-1:0] rd_q;
  logic [rbd_pkg::STATUS_W-1:0]   st_q;
  logic [rbd_pkg::STATUS_W-1:0]   st_next;
  logic [rbd_pkg::PTR_W-1:0]      len_q;
  logic                           peek_ok;
  logic                           peek_ok_next;

  logic [rbd_pkg::PTR_W-1:0] len_cur;
  logic                      full;
  logic                      empty;
  logic                      wr_en;
  logic [rbd_pkg::PTR_W-1:0] wr_addr;
  logic [rbd_pkg::PTR_W-1:0] rd_addr;

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= op;
      value_q <= value[rbd_pkg::DATA_WIDTH-1:0];
    end
  end

  // occupancy from the pointers, wrapping by truncation
  assign len_cur = rbd_pkg::PTR_W'(back_ptr + 1'b1 - front_ptr);
  assign full    = (len_cur == rbd_pkg::LEN_FULL);
  assign empty   = (len_cur == '0);

  // operation decode
  always_comb begin
    front_ptr_next = front_ptr;
    back_ptr_next  = back_ptr;
    st_next        = rbd_pkg::ST_OK;
    peek_ok_next   = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = rbd_pkg::PTR_W'(front_ptr - 1'b1);
    rd_addr        = front_ptr;
    unique case (op_q)
      rbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st_next = rbd_pkg::ST_FULL;
        end else begin
          front_ptr_next = rbd_pkg::PTR_W'(front_ptr - 1'b1);
          wr_en          = 1'b1;
          wr_addr        = front_ptr_next;
        end
      end
      rbd_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st_next = rbd_pkg::ST_FULL;
        end else begin
          back_ptr_next = rbd_pkg::PTR_W'(back_ptr + 1'b1);
          wr_en         = 1'b1;
          wr_addr       = back_ptr_next;
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (empty) begin
          st_next = rbd_pkg::ST_EMPTY;
        end else begin
          front_ptr_next = rbd_pkg::PTR_W'(front_ptr + 1'b1);
        end
      end
      rbd_pkg::OP_POP_BACK: begin
        if (empty) begin
          st_next = rbd_pkg::ST_EMPTY;
        end else begin
          back_ptr_next = rbd_pkg::PTR_W'(back_ptr - 1'b1);
        end
      end
      rbd_pkg::OP_PEEK_FRONT: begin
        rd_addr = front_ptr;
        if (empty) begin
          st_next = rbd_pkg::ST_EMPTY;
        end else begin
          peek_ok_next = 1'b1;
        end
      end
      rbd_pkg::OP_PEEK_BACK: begin
        rd_addr = back_ptr;
        if (empty) begin
          st_next = rbd_pkg::ST_EMPTY;
        end else begin
          peek_ok_next = 1'b1;
        end
      end
      default: begin
        // unused codes leave the state alone and report ok
      end
    endcase
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= rbd_pkg::FRONT_RESET;
      back_ptr  <= rbd_pkg::BACK_RESET;
    end else if (cmd.exec) begin
      front_ptr <= front_ptr_next;
      back_ptr  <= back_ptr_next;
    end
  end

  // slot store with registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        slots[wr_addr] <= value_q;
      end
      rd_q <= slots[rd_addr];
    end
  end

  // per-beat status and length after the operation
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_q    <= st_next;
      peek_ok <= peek_ok_next;
      len_q   <= rbd_pkg::PTR_W'(back_ptr_next + 1'b1 - front_ptr_next);
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      data   <= peek_ok ? rbd_pkg::VALUE_W'(rd_q) : '0;
      status <= st_q;
      length <= rbd_pkg::LENGTH_W'(len_q);
    end
  end

endmodule

FILE: hw/rtl/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue in a circular slot store, one result per operation.
// ----------------------------------------------------------------------------
// Each accepted beat carries one operation (push or pop or peek at either
// end) and yields exactly one result beat with data, status and length.
// An operation runs as capture, then an execute step that updates the
// pointers and makes at most one write and the registered read of the slot
// store, then a load step that fills the output registers. The next beat
// can be taken in the cycle after the result is registered, at the same edge
// that the result is taken; a result held back by the output side holds back
// the input as well, so no new beat is taken before the last result is taken.
// The store holds up to DEPTH-1 words; full pushes and empty pops or peeks
// report an error status and change nothing.
module ring_buffer_deque (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rbd_pkg::OP_W-1:0]      op,
  input  logic [rbd_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rbd_pkg::VALUE_W-1:0]   data,
  output logic [rbd_pkg::STATUS_W-1:0]  status,
  output logic [rbd_pkg::LENGTH_W-1:0]  length
);

  rbd_pkg::rbd_cmd_t cmd;

  // sequencer
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // store, pointers and result registers
  rbd_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .op     (op),
    .value  (value),
    .data   (data),
    .status (status),
    .length (length)
  );

endmodule

FILE: hw/rtl/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks on the deque's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rbd_pkg::OP_W-1:0]      op,
  input logic [rbd_pkg::VALUE_W-1:0]   value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rbd_pkg::VALUE_W-1:0]   data,
  input logic [rbd_pkg::STATUS_W-1:0]  status,
  input logic [rbd_pkg::LENGTH_W-1:0]  length
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status)
      && $stable(length))
    else $error("result beat changed while stalled");

  // one operation at a time: no beat is taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation is in flight");

  // a refused push only happens at full occupancy
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rbd_pkg::ST_FULL |->
      length == rbd_pkg::LENGTH_W'(rbd_pkg::DEPTH - 1) && data == '0)
    else $error("full status with wrong length or data");

  // a refused pop or peek only happens when empty, with zero data
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rbd_pkg::ST_EMPTY |-> length == '0 && data == '0)
    else $error("empty status with nonzero length or data");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == rbd_pkg::ST_OK || status == rbd_pkg::ST_FULL
      || status == rbd_pkg::ST_EMPTY)
    else $error("undefined status code");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);
